FILE: sv/xed_pkg.sv
// Package for the XML entity decoder: byte type, parse mode codes,
// whitespace codes and the table of named entities.
// Depends on nothing; only the decoder top level imports it.
package xed_pkg;

    typedef logic [7:0] t_byte;

    localparam int RES_MAX    = 7;
    localparam int HOLD_DEPTH = 4;
    localparam int NAME_COUNT = 5;
    localparam int NAME_SLOTS = 8;

    localparam logic [2:0] MODE_LEAD = 3'd0;
    localparam logic [2:0] MODE_TEXT = 3'd1;
    localparam logic [2:0] MODE_AMP  = 3'd2;
    localparam logic [2:0] MODE_HASH = 3'd3;
    localparam logic [2:0] MODE_DEC  = 3'd4;
    localparam logic [2:0] MODE_HEX  = 3'd5;

    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_CR    = 8'h0d;
    localparam t_byte CH_LF    = 8'h0a;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_X     = 8'h78;

    // Names after the ampersand, zero padded, with their lengths and results.
    localparam t_byte ENT_NAME [NAME_COUNT][NAME_SLOTS] = '{
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [NAME_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
    localparam t_byte ENT_CHAR [NAME_COUNT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

endpackage

FILE: sv/xed_in_if.sv
// Input channel of the XML entity decoder: one raw text word per handshake.
// Standalone; no package is needed.
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: sv/xed_out_if.sv
// Output channel of the XML entity decoder: one decoded word per handshake.
// Standalone; no package is needed.
interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

FILE: sv/xml_entity_decoder.sv
// XML entity decoder top level: input register, parse logic, result buffer.
// Depends on xed_pkg, xed_in_if and xed_out_if.
//
// Channel   Port    Dir  Word
// input     i_in    in   in_byte[7:0], in_last
// output    o_out   out  out_byte[7:0], has_byte, out_last
//
// An input word is taken into an input register and parsed from there into a
// result buffer of up to seven words; parsing waits until the buffer is empty
// or its last word is leaving. The output port drains the buffer one word per
// cycle while o_out.ready is high, so a word with several results holds the
// parser until they drain; words with zero or one result go one per ready cycle.
// Reset is synchronous and active low; it returns the parser to the
// leading-whitespace state and empties both registers.
module xml_entity_decoder
    import xed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    xed_in_if.sink     i_in,
    xed_out_if.source  o_out
);

    logic       r_in_v;
    t_byte      r_in_byte;
    logic       r_in_last;

    logic [2:0] r_mode, n_mode;
    t_byte      r_ebuf [HOLD_DEPTH];
    t_byte      n_ebuf [HOLD_DEPTH];
    logic [2:0] r_ecnt, n_ecnt;
    t_byte      r_acc, n_acc;
    logic       r_space, n_space;

    t_byte      r_ob [RES_MAX];
    t_byte      n_ob [RES_MAX];
    logic [2:0] r_ocnt, n_ocnt;
    logic [2:0] r_ordx;
    logic       r_ohas, n_ohas;
    logic       r_olast;

    logic       adv;
    logic       out_fire;
    logic       in_fire;

    logic       do_text;
    logic       do_num;
    logic       num_hex;
    logic       is_digit;
    logic [3:0] digit;
    logic       full_hit;
    logic       part_hit;
    t_byte      full_char;
    logic       name_ok;

    assign out_fire = (r_ocnt != 3'd0) && o_out.ready;
    assign adv      = r_in_v && ((r_ocnt == 3'd0) || ((r_ocnt == 3'd1) && o_out.ready));
    assign i_in.ready = !r_in_v || adv;
    assign in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid    = (r_ocnt != 3'd0);
    assign o_out.out_byte = r_ob[r_ordx];
    assign o_out.has_byte = r_ohas;
    assign o_out.out_last = r_olast && (r_ocnt == 3'd1);

    // Named entity match against the held prefix and the current byte.
    always_comb begin
        full_hit  = 1'b0;
        part_hit  = 1'b0;
        full_char = 8'h00;
        name_ok   = 1'b0;
        for (int e = 0; e < NAME_COUNT; e++) begin
            name_ok = (r_ecnt < ENT_LEN[e]) && (ENT_NAME[e][r_ecnt] == r_in_byte);
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if ((3'(i) < r_ecnt) && (r_ebuf[i] != ENT_NAME[e][i])) begin
                    name_ok = 1'b0;
                end
            end
            if (name_ok && !full_hit) begin
                if ((r_ecnt + 3'd1) == ENT_LEN[e]) begin
                    full_hit  = 1'b1;
                    full_char = ENT_CHAR[e];
                end else begin
                    part_hit = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_ebuf  = r_ebuf;
        n_ecnt  = r_ecnt;
        n_acc   = r_acc;
        n_space = r_space;
        n_ocnt  = 3'd0;
        n_ohas  = 1'b1;
        do_text = 1'b0;
        do_num  = 1'b0;
        num_hex = 1'b0;
        for (int k = 0; k < RES_MAX; k++) begin
            n_ob[k] = 8'h00;
        end

        case (r_mode)
            MODE_AMP: begin
                if ((r_ecnt == 3'd0) && (r_in_byte == CH_HASH)) begin
                    n_mode = MODE_HASH;
                    n_acc  = 8'h00;
                end else if (full_hit) begin
                    n_ob[n_ocnt] = full_char;
                    n_ocnt       = n_ocnt + 3'd1;
                    n_ecnt       = 3'd0;
                    n_mode       = MODE_TEXT;
                end else if (part_hit) begin
                    n_ebuf[r_ecnt[1:0]] = r_in_byte;
                    n_ecnt              = r_ecnt + 3'd1;
                end else begin
                    n_ob[n_ocnt] = CH_AMP;
                    n_ocnt       = n_ocnt + 3'd1;
                    for (int i = 0; i < HOLD_DEPTH; i++) begin
                        if (3'(i) < r_ecnt) begin
                            n_ob[n_ocnt] = r_ebuf[i];
                            n_ocnt       = n_ocnt + 3'd1;
                        end
                    end
                    n_ecnt  = 3'd0;
                    n_mode  = MODE_TEXT;
                    do_text = 1'b1;
                end
            end
            MODE_HASH: begin
                if (r_in_byte == CH_X) begin
                    n_mode = MODE_HEX;
                end else begin
                    n_mode = MODE_DEC;
                    do_num = 1'b1;
                end
            end
            MODE_DEC: begin
                do_num = 1'b1;
            end
            MODE_HEX: begin
                do_num  = 1'b1;
                num_hex = 1'b1;
            end
            default: begin
                do_text = 1'b1;
            end
        endcase

        is_digit = 1'b0;
        digit    = 4'd0;
        if (r_in_byte inside {[8'h30:8'h39]}) begin
            is_digit = 1'b1;
            digit    = r_in_byte[3:0];
        end else if (num_hex && (r_in_byte inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
            is_digit = 1'b1;
            digit    = r_in_byte[3:0] + 4'd9;
        end

        if (do_num) begin
            if (is_digit) begin
                if (num_hex) begin
                    n_acc = {r_acc[3:0], 4'd0} + {4'd0, digit};
                end else begin
                    n_acc = {r_acc[4:0], 3'd0} + {r_acc[6:0], 1'b0} + {4'd0, digit};
                end
            end else begin
                n_ob[n_ocnt] = r_acc;
                n_ocnt       = n_ocnt + 3'd1;
                n_mode       = MODE_TEXT;
            end
        end

        if (do_text) begin
            if (r_in_byte inside {CH_SPACE, CH_CR, CH_LF, CH_TAB}) begin
                if (n_mode != MODE_LEAD) begin
                    n_space = 1'b1;
                end
            end else begin
                if (n_space) begin
                    n_ob[n_ocnt] = CH_SPACE;
                    n_ocnt       = n_ocnt + 3'd1;
                    n_space      = 1'b0;
                end
                if (r_in_byte == CH_AMP) begin
                    n_mode = MODE_AMP;
                    n_ecnt = 3'd0;
                end else begin
                    n_mode       = MODE_TEXT;
                    n_ob[n_ocnt] = r_in_byte;
                    n_ocnt       = n_ocnt + 3'd1;
                end
            end
        end

        if (r_in_last) begin
            if (n_mode == MODE_AMP) begin
                n_ob[n_ocnt] = CH_AMP;
                n_ocnt       = n_ocnt + 3'd1;
                for (int i = 0; i < HOLD_DEPTH; i++) begin
                    if (3'(i) < n_ecnt) begin
                        n_ob[n_ocnt] = n_ebuf[i];
                        n_ocnt       = n_ocnt + 3'd1;
                    end
                end
            end else if ((n_mode == MODE_HASH) || (n_mode == MODE_DEC)
                         || (n_mode == MODE_HEX)) begin
                n_ob[n_ocnt] = n_acc;
                n_ocnt       = n_ocnt + 3'd1;
            end
            n_mode  = MODE_LEAD;
            n_ecnt  = 3'd0;
            n_acc   = 8'h00;
            n_space = 1'b0;
            if (n_ocnt == 3'd0) begin
                n_ob[0] = 8'h00;
                n_ocnt  = 3'd1;
                n_ohas  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mode  <= MODE_LEAD;
            r_ecnt  <= 3'd0;
            r_acc   <= 8'h00;
            r_space <= 1'b0;
            r_ocnt  <= 3'd0;
            r_ordx  <= 3'd0;
        end else begin
            if (in_fire) begin
                r_in_v <= 1'b1;
            end else if (adv) begin
                r_in_v <= 1'b0;
            end
            if (adv) begin
                r_mode  <= n_mode;
                r_ecnt  <= n_ecnt;
                r_acc   <= n_acc;
                r_space <= n_space;
                r_ocnt  <= n_ocnt;
                r_ordx  <= 3'd0;
            end else if (out_fire) begin
                r_ocnt <= r_ocnt - 3'd1;
                r_ordx <= r_ordx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
        if (adv) begin
            r_ebuf  <= n_ebuf;
            r_ob    <= n_ob;
            r_ohas  <= n_ohas;
            r_olast <= r_in_last;
        end
    end

    // The parser only loads the buffer when it is empty or its last word is leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> ((r_ocnt == 3'd0) || ((r_ocnt == 3'd1) && o_out.ready)))
        else $error("result buffer overwritten while words are pending");

    // An empty result word only appears as the end of a string.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_byte) |-> o_out.out_last)
        else $error("empty result word without end marker");

    // A string end returns the parser to its reset state.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(adv) && $past(r_in_last)) |->
        ((r_mode == MODE_LEAD) && (r_ecnt == 3'd0) && !r_space && (r_acc == 8'h00)))
        else $error("parser state not cleared at end of string");

    // A held entity prefix never exceeds the longest name minus its terminator.
    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= 3'(HOLD_DEPTH))
        else $error("entity prefix count out of range");

    // The read index plus the remaining count never runs past the buffer.
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (({1'b0, r_ordx} + {1'b0, r_ocnt}) <= 4'(RES_MAX)))
        else $error("result read beyond buffer");

endmodule
